FILE: hdl/brfms_pkg.sv
package brfms_pkg;

   // Request kinds.
   localparam logic [2:0] KIND_READ_REG   = 3'd0;
   localparam logic [2:0] KIND_WRITE_REG  = 3'd1;
   localparam logic [2:0] KIND_WRITE_CPSR = 3'd2;
   localparam logic [2:0] KIND_WRITE_SPSR = 3'd3;
   localparam logic [2:0] KIND_SWITCH     = 3'd4;
   localparam logic [2:0] KIND_EXCEPTION  = 3'd5;
   localparam logic [2:0] KIND_WAIT_IRQ   = 3'd6;
   localparam logic [2:0] KIND_NOP        = 3'd7;

   // Mode codes.
   localparam logic [4:0] MODE_USR = 5'h10;
   localparam logic [4:0] MODE_FIQ = 5'h11;
   localparam logic [4:0] MODE_IRQ = 5'h12;
   localparam logic [4:0] MODE_SVC = 5'h13;
   localparam logic [4:0] MODE_ABT = 5'h17;
   localparam logic [4:0] MODE_UND = 5'h1B;
   localparam logic [4:0] MODE_SYS = 5'h1F;

   // Bank numbers.
   localparam logic [2:0] BANK_USR = 3'd0;
   localparam logic [2:0] BANK_SVC = 3'd1;
   localparam logic [2:0] BANK_ABT = 3'd2;
   localparam logic [2:0] BANK_UND = 3'd3;
   localparam logic [2:0] BANK_IRQ = 3'd4;
   localparam logic [2:0] BANK_FIQ = 3'd5;

   localparam int NUM_BANKS = 6;
   localparam int NUM_SPSR  = 5;
   localparam int NUM_VIS   = 15;
   localparam int NUM_FIQ_LOW = 5;

   localparam logic [3:0] REG_NONE = 4'd15;
   localparam logic [4:0] VEC_IRQ  = 5'h18;
   localparam logic [4:0] VEC_OFFSET_MASK = 5'h1C;
   localparam logic [31:0] STATUS_RESET = 32'h0000_001F;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  reg_index;
      logic [31:0] write_value;
      logic [4:0]  new_mode;
      logic [4:0]  vector_offset;
      logic [31:0] return_address;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [31:0] status_word;
      logic [31:0] saved_status;
      logic [4:0]  previous_mode;
      logic [31:0] target_address;
      logic        waiting_irq;
      logic        bad_mode;
      logic        halted;
   } rsp_type;

   typedef struct packed {
      logic       known;
      logic [2:0] bank;
   } bank_sel_type;

   typedef struct packed {
      logic       known;
      logic [4:0] mode;
   } vec_mode_type;

   // Command from the controller to the datapath.
   typedef struct packed {
      logic execute;
   } ctl_cmd_type;

   function automatic bank_sel_type bank_of(input logic [4:0] mode);
      bank_sel_type r;
      r.known = 1'b1;
      unique case (mode)
         MODE_USR, MODE_SYS: r.bank = BANK_USR;
         MODE_SVC:           r.bank = BANK_SVC;
         MODE_ABT:           r.bank = BANK_ABT;
         MODE_UND:           r.bank = BANK_UND;
         MODE_IRQ:           r.bank = BANK_IRQ;
         MODE_FIQ:           r.bank = BANK_FIQ;
         default: begin
            r.known = 1'b0;
            r.bank  = BANK_USR;
         end
      endcase
      return r;
   endfunction

   function automatic vec_mode_type vector_mode(input logic [4:0] offset);
      vec_mode_type r;
      r.known = 1'b1;
      unique case (offset)
         5'h00:   r.mode = MODE_SVC;
         5'h04:   r.mode = MODE_UND;
         5'h08:   r.mode = MODE_SVC;
         5'h0C:   r.mode = MODE_ABT;
         5'h10:   r.mode = MODE_ABT;
         5'h18:   r.mode = MODE_IRQ;
         5'h1C:   r.mode = MODE_FIQ;
         default: begin
            r.known = 1'b0;
            r.mode  = MODE_USR;
         end
      endcase
      return r;
   endfunction

endpackage

FILE: hdl/banked_register_file_mode_switch.sv
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   req_data (brfms_pkg::req_type)
// rsp       out        rsp_valid/rsp_stall   rsp_data (brfms_pkg::rsp_type)
// csr       in         csr_write_enable      csr_write_data (vector base)
//
// Each request is executed in the cycle it is accepted and its result is held
// in the output register, so the sustained rate is one request per cycle
// while the receiver does not stall; the datapath does the bank transfer in that step.
// The synchronous reset loads system mode into the status and saved status
// words and clears all registers, banks and the wait flag at once.
// A request is taken while a result waits only if that result drains the same
// cycle; a stalled result holds the request channel stalled.
module banked_register_file_mode_switch (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  brfms_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output brfms_pkg::rsp_type rsp_data,
   input  logic               csr_write_enable,
   input  logic [31:0]        csr_write_data
);
   import brfms_pkg::*;

   // The controller owns the handshakes and tells the datapath when to
   // commit a request into the register file and the result register.
   ctl_cmd_type cmd;

   brfms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // The datapath holds the visible registers, the mode banks, the saved
   // status registers and the vector base, and forms each result.
   brfms_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_data         (req_data),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

endmodule

FILE: hdl/brfms_ctrl.sv
module brfms_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output brfms_pkg::ctl_cmd_type cmd
);
   import brfms_pkg::*;

   typedef enum logic {
      ST_EMPTY,
      ST_FULL
   } state_type;

   state_type state_ff, state_in;
   logic      out_free;

   // The result register can take a new result when empty or when drained now.
   assign out_free    = (state_ff == ST_EMPTY) || !rsp_stall;
   assign req_stall   = !out_free;
   assign cmd.execute = req_valid && out_free;
   assign rsp_valid   = (state_ff == ST_FULL);

   always_comb begin
      state_in = state_ff;
      if (cmd.execute) begin
         state_in = ST_FULL;
      end else if (out_free) begin
         state_in = ST_EMPTY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/brfms_datapath.sv
module brfms_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  brfms_pkg::ctl_cmd_type cmd,
   input  brfms_pkg::req_type     req_data,
   output brfms_pkg::rsp_type     rsp_data,
   input  logic                   csr_write_enable,
   input  logic [31:0]            csr_write_data
);
   import brfms_pkg::*;

   logic [31:0] vis_ff     [NUM_VIS];
   logic [31:0] vis_in     [NUM_VIS];
   logic [31:0] bank13_ff  [NUM_BANKS];
   logic [31:0] bank13_in  [NUM_BANKS];
   logic [31:0] bank14_ff  [NUM_BANKS];
   logic [31:0] bank14_in  [NUM_BANKS];
   logic [31:0] fiq_low_ff [NUM_FIQ_LOW];
   logic [31:0] fiq_low_in [NUM_FIQ_LOW];
   logic [31:0] spsr_ff    [NUM_SPSR];
   logic [31:0] spsr_in    [NUM_SPSR];
   logic [31:0] status_ff, status_in;
   logic [31:0] cur_spsr_ff, cur_spsr_in;
   logic        wait_ff, wait_in;
   logic [31:0] vbase_ff;
   rsp_type     rsp_ff, rsp_in;

   bank_sel_type old_sel;
   bank_sel_type new_sel;
   vec_mode_type vec_sel;
   logic [4:0]   offset;
   logic [4:0]   tgt_mode;
   logic         do_switch;
   logic         do_exc;

   assign offset   = req_data.vector_offset & VEC_OFFSET_MASK;
   assign vec_sel  = vector_mode(offset);
   // An exception takes its mode from the vector; a switch names it directly.
   assign tgt_mode = (req_data.kind == KIND_EXCEPTION) ? vec_sel.mode : req_data.new_mode;
   assign old_sel  = bank_of(status_ff[4:0]);
   assign new_sel  = bank_of(tgt_mode);

   always_comb begin
      vis_in      = vis_ff;
      bank13_in   = bank13_ff;
      bank14_in   = bank14_ff;
      fiq_low_in  = fiq_low_ff;
      spsr_in     = spsr_ff;
      status_in   = status_ff;
      cur_spsr_in = cur_spsr_ff;
      wait_in     = wait_ff;
      do_switch   = 1'b0;
      do_exc      = 1'b0;
      rsp_in      = '0;
      rsp_in.previous_mode = status_ff[4:0];

      unique case (req_data.kind)
         KIND_READ_REG: begin
            if (req_data.reg_index != REG_NONE) begin
               rsp_in.read_data = vis_ff[req_data.reg_index];
            end
         end
         KIND_WRITE_REG: begin
            if (req_data.reg_index != REG_NONE) begin
               vis_in[req_data.reg_index] = req_data.write_value;
            end
         end
         KIND_WRITE_CPSR: begin
            status_in = {req_data.write_value[31:5], status_ff[4:0]};
         end
         KIND_WRITE_SPSR: begin
            cur_spsr_in = req_data.write_value;
         end
         KIND_SWITCH: begin
            if (new_sel.known) begin
               do_switch = 1'b1;
            end else begin
               rsp_in.bad_mode = 1'b1;
            end
         end
         KIND_EXCEPTION: begin
            if (vec_sel.known) begin
               do_switch = 1'b1;
               do_exc    = 1'b1;
            end else begin
               rsp_in.halted = 1'b1;
            end
         end
         KIND_WAIT_IRQ: begin
            wait_in = 1'b1;
         end
         KIND_NOP: begin
         end
      endcase

      // Store the outgoing bank, then load the incoming one; r8 to r12 swap with their FIQ copies
      // when only one side is FIQ. When both are the same bank nothing is loaded.
      if (do_switch) begin
         bank13_in[old_sel.bank] = vis_ff[13];
         bank14_in[old_sel.bank] = vis_ff[14];
         if (old_sel.bank != BANK_USR) begin
            spsr_in[old_sel.bank - 3'd1] = cur_spsr_ff;
         end
         if (old_sel.bank != new_sel.bank) begin
            vis_in[13] = bank13_ff[new_sel.bank];
            vis_in[14] = bank14_ff[new_sel.bank];
            if (new_sel.bank != BANK_USR) begin
               cur_spsr_in = spsr_ff[new_sel.bank - 3'd1];
            end
         end
         if ((old_sel.bank == BANK_FIQ) != (new_sel.bank == BANK_FIQ)) begin
            for (int i = 0; i < NUM_FIQ_LOW; i++) begin
               vis_in[8 + i] = fiq_low_ff[i];
               fiq_low_in[i] = vis_ff[8 + i];
            end
         end
         status_in = {status_ff[31:5], tgt_mode};
      end

      if (do_exc) begin
         vis_in[14]  = req_data.return_address;
         cur_spsr_in = status_ff;
         status_in   = {status_ff[31:8], 1'b1, status_ff[6], 1'b0, tgt_mode};
         rsp_in.target_address = vbase_ff + {27'd0, offset};
         if (offset == VEC_IRQ) begin
            wait_in = 1'b0;
         end
      end

      rsp_in.status_word  = status_in;
      rsp_in.saved_status = cur_spsr_in;
      rsp_in.waiting_irq  = wait_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_VIS; i++) begin
            vis_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_BANKS; i++) begin
            bank13_ff[i] <= '0;
            bank14_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_FIQ_LOW; i++) begin
            fiq_low_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_SPSR; i++) begin
            spsr_ff[i] <= '0;
         end
         status_ff   <= STATUS_RESET;
         cur_spsr_ff <= STATUS_RESET;
         wait_ff     <= 1'b0;
         vbase_ff    <= '0;
      end else begin
         if (cmd.execute) begin
            vis_ff      <= vis_in;
            bank13_ff   <= bank13_in;
            bank14_ff   <= bank14_in;
            fiq_low_ff  <= fiq_low_in;
            spsr_ff     <= spsr_in;
            status_ff   <= status_in;
            cur_spsr_ff <= cur_spsr_in;
            wait_ff     <= wait_in;
         end
         if (csr_write_enable) begin
            vbase_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: test/brfms_checker.sv
module brfms_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  brfms_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  brfms_pkg::rsp_type rsp_data,
   input  logic               csr_write_enable,
   input  logic [31:0]        csr_write_data,
   output int                 mismatch_count,
   output int                 awaited_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import brfms_pkg::*;

   localparam logic [31:0] STATUS_T = 32'h0000_0020;
   localparam logic [31:0] STATUS_I = 32'h0000_0080;

   localparam logic [4:0] VEC_RESET    = 5'h00;
   localparam logic [4:0] VEC_UNDEF    = 5'h04;
   localparam logic [4:0] VEC_SWI      = 5'h08;
   localparam logic [4:0] VEC_PREFETCH = 5'h0C;
   localparam logic [4:0] VEC_DATA     = 5'h10;
   localparam logic [4:0] VEC_FIQ      = 5'h1C;

   logic [31:0] gpr [0:14];
   logic [31:0] shadow [0:16];
   logic [31:0] shadow_spsr [0:4];
   logic [31:0] cpsr;
   logic [31:0] spsr;
   logic [31:0] vbase;
   logic        irq_wait;
   rsp_type     awaited_rsp_q [$];
   int          rsp_seen;

   // Bank number for a mode code, or -1 when the code names no mode.
   function automatic int bank_for(input logic [4:0] mode);
      case (mode)
         MODE_USR, MODE_SYS: return BANK_USR;
         MODE_SVC:           return BANK_SVC;
         MODE_ABT:           return BANK_ABT;
         MODE_UND:           return BANK_UND;
         MODE_IRQ:           return BANK_IRQ;
         MODE_FIQ:           return BANK_FIQ;
         default:            return -1;
      endcase
   endfunction

   function automatic void exchange_fiq_low();
      logic [31:0] t;
      for (int i = 0; i < NUM_FIQ_LOW; i++) begin
         t = gpr[8 + i];
         gpr[8 + i] = shadow[10 + i];
         shadow[10 + i] = t;
      end
   endfunction

   function automatic void park_bank(input int b);
      if (b == BANK_USR) begin
         shadow[0] = gpr[13];
         shadow[1] = gpr[14];
      end else if (b == BANK_FIQ) begin
         exchange_fiq_low();
         shadow[15] = gpr[13];
         shadow[16] = gpr[14];
         shadow_spsr[4] = spsr;
      end else begin
         shadow[2 * b] = gpr[13];
         shadow[2 * b + 1] = gpr[14];
         shadow_spsr[b - 1] = spsr;
      end
   endfunction

   function automatic void unpark_bank(input int b);
      if (b == BANK_USR) begin
         gpr[13] = shadow[0];
         gpr[14] = shadow[1];
      end else if (b == BANK_FIQ) begin
         exchange_fiq_low();
         gpr[13] = shadow[15];
         gpr[14] = shadow[16];
         spsr = shadow_spsr[4];
      end else begin
         gpr[13] = shadow[2 * b];
         gpr[14] = shadow[2 * b + 1];
         spsr = shadow_spsr[b - 1];
      end
   endfunction

   function automatic void enter_mode(input logic [4:0] mode);
      park_bank(bank_for(cpsr[4:0]));
      unpark_bank(bank_for(mode));
      cpsr[4:0] = mode;
   endfunction

   // Applies one request to the shadow state and returns the result it must produce.
   function automatic rsp_type run_request(input req_type r);
      rsp_type     o;
      logic [4:0]  off;
      logic [4:0]  emode;
      logic        vec_known;
      logic [31:0] old_cpsr;
      o = '0;
      o.previous_mode = cpsr[4:0];
      off = r.vector_offset & VEC_OFFSET_MASK;
      case (r.kind)
         KIND_READ_REG: begin
            if (r.reg_index != REG_NONE) o.read_data = gpr[r.reg_index];
         end
         KIND_WRITE_REG: begin
            if (r.reg_index != REG_NONE) gpr[r.reg_index] = r.write_value;
         end
         KIND_WRITE_CPSR: cpsr = {r.write_value[31:5], cpsr[4:0]};
         KIND_WRITE_SPSR: spsr = r.write_value;
         KIND_SWITCH: begin
            if (bank_for(r.new_mode) < 0) o.bad_mode = 1'b1;
            else enter_mode(r.new_mode);
         end
         KIND_EXCEPTION: begin
            vec_known = 1'b1;
            emode = MODE_USR;
            case (off)
               VEC_RESET, VEC_SWI:     emode = MODE_SVC;
               VEC_UNDEF:              emode = MODE_UND;
               VEC_PREFETCH, VEC_DATA: emode = MODE_ABT;
               VEC_IRQ:                emode = MODE_IRQ;
               VEC_FIQ:                emode = MODE_FIQ;
               default:                vec_known = 1'b0;
            endcase
            if (!vec_known) begin
               o.halted = 1'b1;
            end else begin
               old_cpsr = cpsr;
               enter_mode(emode);
               gpr[14] = r.return_address;
               spsr = old_cpsr;
               cpsr = (cpsr & ~STATUS_T) | STATUS_I;
               o.target_address = vbase + 32'(off);
               if (off == VEC_IRQ) irq_wait = 1'b0;
            end
         end
         KIND_WAIT_IRQ: irq_wait = 1'b1;
         default: ;
      endcase
      o.status_word = cpsr;
      o.saved_status = spsr;
      o.waiting_irq = irq_wait;
      return o;
   endfunction

   function automatic void compare_rsp(input rsp_type want, input rsp_type got);
      string diffs;
      diffs = "";
      if (got.read_data !== want.read_data)
         diffs = {diffs, $sformatf(" read_data exp %h got %h", want.read_data, got.read_data)};
      if (got.status_word !== want.status_word)
         diffs = {diffs, $sformatf(" status exp %h got %h", want.status_word, got.status_word)};
      if (got.saved_status !== want.saved_status)
         diffs = {diffs, $sformatf(" saved exp %h got %h", want.saved_status, got.saved_status)};
      if (got.previous_mode !== want.previous_mode)
         diffs = {diffs, $sformatf(" prev_mode exp %h got %h", want.previous_mode,
                                   got.previous_mode)};
      if (got.target_address !== want.target_address)
         diffs = {diffs, $sformatf(" target exp %h got %h", want.target_address,
                                   got.target_address)};
      if (got.waiting_irq !== want.waiting_irq)
         diffs = {diffs, $sformatf(" wait exp %b got %b", want.waiting_irq, got.waiting_irq)};
      if (got.bad_mode !== want.bad_mode)
         diffs = {diffs, $sformatf(" bad_mode exp %b got %b", want.bad_mode, got.bad_mode)};
      if (got.halted !== want.halted)
         diffs = {diffs, $sformatf(" halted exp %b got %b", want.halted, got.halted)};
      if (diffs != "") begin
         mismatch_count++;
         if (mismatch_count <= 10) $display("Mismatch on result %0d:%s", rsp_seen, diffs);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (gpr[i]) gpr[i] = '0;
         foreach (shadow[i]) shadow[i] = '0;
         foreach (shadow_spsr[i]) shadow_spsr[i] = '0;
         cpsr = STATUS_RESET;
         spsr = STATUS_RESET;
         vbase = '0;
         irq_wait = 1'b0;
         awaited_rsp_q.delete();
         rsp_seen = 0;
         mismatch_count = 0;
         awaited_count <= 0;
      end else begin
         if (csr_write_enable) vbase = csr_write_data;
         if (req_valid && !req_stall) awaited_rsp_q.push_back(run_request(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Unexpected result %0d with no request outstanding: status %h",
                           rsp_seen, rsp_data.status_word);
            end else begin
               compare_rsp(awaited_rsp_q.pop_front(), rsp_data);
            end
            rsp_seen++;
         end
         awaited_count <= awaited_rsp_q.size();
      end
   end

endmodule

FILE: test/tb_banked_register_file_mode_switch.sv
module tb_banked_register_file_mode_switch;
   timeunit 1ns;
   timeprecision 1ps;
   import brfms_pkg::*;

   // A code in the mode field that belongs to no processor mode.
   localparam logic [4:0] NOT_A_MODE = 5'h00;
   // Length of the long output hold-off, in cycles.
   localparam int LONG_HOLD = 60;
   localparam int RANDOM_PER_PHASE = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   req_type     req_data = '0;
   logic        req_stall;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_enable = 1'b0;
   logic [31:0] csr_write_data = '0;

   int mismatch_count;
   int awaited_count;

   // The sender's idle rate is only used by the stimulus process itself. The receiver's rate
   // and the hold-off token cross into the receiver process, so they change by nonblocking
   // assignment only.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_token = 0;
   int hold_done = 0;
   int hold_left = 0;

   int sent_total = 0;
   int sent_switches = 0;
   int sent_exceptions = 0;

   banked_register_file_mode_switch dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // The checker watches both channels and the vector base writes, keeps its own copy of
   // the register file and compares every result with the one it predicted.
   brfms_checker result_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .awaited_count    (awaited_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Receiver. Each cycle it stalls at the current idle rate, except that a new hold-off
   // token makes it stall for a long unbroken stretch. During that stretch the output
   // register stays full, so the block has to stall its request channel.
   always @(posedge clock) begin
      if (hold_token != hold_done) begin
         hold_done <= hold_token;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Offers one request and returns at the edge where it was taken. The task is always
   // entered at a rising edge, so valid gets exactly one assignment per edge: it is dropped
   // only when an idle gap is chosen, and otherwise stays high into the next request.
   task automatic send_req(input req_type r);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      sent_total++;
      if (r.kind == KIND_SWITCH) sent_switches++;
      if (r.kind == KIND_EXCEPTION) sent_exceptions++;
   endtask

   // Stops offering and waits until every predicted result has been taken. The first edge
   // lets the checker publish the count that includes the last accepted request.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_count != 0) @(posedge clock);
   endtask

   // The vector base is only written while nothing is in flight.
   task automatic set_vector_base(input logic [31:0] base);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data <= base;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic req_type make_req(input logic [2:0] kind, input logic [3:0] idx,
                                        input logic [31:0] value, input logic [4:0] mode,
                                        input logic [4:0] offset, input logic [31:0] ret);
      req_type r;
      r.kind = kind;
      r.reg_index = idx;
      r.write_value = value;
      r.new_mode = mode;
      r.vector_offset = offset;
      r.return_address = ret;
      return r;
   endfunction

   // Random requests lean towards register traffic, legal mode switches and aligned vectors,
   // since that is what exercises the banks. A share of unknown modes, unaligned offsets,
   // register fifteen and idle kinds is mixed in.
   function automatic req_type random_req();
      req_type    r;
      int         pick;
      logic [4:0] modes [7];
      modes = '{MODE_USR, MODE_FIQ, MODE_IRQ, MODE_SVC, MODE_ABT, MODE_UND, MODE_SYS};
      pick = $urandom_range(99);
      if (pick < 22) r.kind = KIND_READ_REG;
      else if (pick < 40) r.kind = KIND_WRITE_REG;
      else if (pick < 47) r.kind = KIND_WRITE_CPSR;
      else if (pick < 53) r.kind = KIND_WRITE_SPSR;
      else if (pick < 70) r.kind = KIND_SWITCH;
      else if (pick < 86) r.kind = KIND_EXCEPTION;
      else if (pick < 93) r.kind = KIND_WAIT_IRQ;
      else r.kind = KIND_NOP;
      r.reg_index = ($urandom_range(15) == 0) ? REG_NONE : 4'($urandom_range(14));
      case ($urandom_range(3))
         0:       r.write_value = '0;
         1:       r.write_value = '1;
         default: r.write_value = $urandom;
      endcase
      r.new_mode = ($urandom_range(4) == 0) ? 5'($urandom) : modes[$urandom_range(6)];
      r.vector_offset = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7) * 4);
      r.return_address = $urandom;
      return r;
   endfunction

   initial begin
      logic [31:0] bases [3];
      int          send_pcts [3];
      int          recv_pcts [3];
      bases = '{32'hFFFF_0000, 32'($urandom_range(32'hFFFF_0000)), 32'h0000_0000};
      send_pcts = '{30, 54, 0};
      recv_pcts = '{54, 30, 0};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 30;
      recv_idle_pct <= 54;

      // Directed part: register extremes, the ignored register fifteen, status writes that
      // try to touch the mode bits, a saved status write in system mode, the fast-interrupt
      // bank and a switch into the mode already current, an unknown mode code and a switch to
      // system mode, then every vector including the reserved one and unaligned offsets.
      send_req(make_req(KIND_READ_REG, 4'd0, '0, MODE_SYS, '0, '0));
      send_req(make_req(KIND_WRITE_REG, 4'd0, '1, MODE_SYS, '0, '0));
      send_req(make_req(KIND_READ_REG, 4'd0, '0, MODE_SYS, '0, '0));
      send_req(make_req(KIND_WRITE_REG, REG_NONE, 32'h1234_5678, MODE_SYS, '0, '0));
      send_req(make_req(KIND_READ_REG, REG_NONE, '0, MODE_SYS, '0, '0));
      send_req(make_req(KIND_WRITE_CPSR, 4'd0, '1, MODE_SYS, '0, '0));
      send_req(make_req(KIND_WRITE_CPSR, 4'd0, '0, MODE_SYS, '0, '0));
      send_req(make_req(KIND_WRITE_SPSR, 4'd0, 32'hA5A5_A5A5, MODE_SYS, '0, '0));
      send_req(make_req(KIND_WRITE_REG, 4'd8, 32'h8888_8888, MODE_SYS, '0, '0));
      send_req(make_req(KIND_SWITCH, 4'd0, '0, MODE_FIQ, '0, '0));
      send_req(make_req(KIND_WRITE_REG, 4'd8, 32'hF1F1_0008, MODE_SYS, '0, '0));
      send_req(make_req(KIND_SWITCH, 4'd0, '0, MODE_FIQ, '0, '0));
      send_req(make_req(KIND_READ_REG, 4'd8, '0, MODE_SYS, '0, '0));
      send_req(make_req(KIND_SWITCH, 4'd0, '0, MODE_USR, '0, '0));
      send_req(make_req(KIND_READ_REG, 4'd8, '0, MODE_SYS, '0, '0));
      send_req(make_req(KIND_SWITCH, 4'd0, '0, NOT_A_MODE, '0, '0));
      send_req(make_req(KIND_SWITCH, 4'd0, '0, '1, '0, '0));
      // Every vector slot once; odd slots carry junk in the two low offset bits.
      for (int v = 0; v < 8; v++)
         send_req(make_req(KIND_EXCEPTION, 4'd0, '0, MODE_SYS, 5'(4 * v + (v & 1) * 3),
                           32'($urandom)));
      // Waiting for an interrupt, then the interrupt entry that ends the wait.
      send_req(make_req(KIND_WAIT_IRQ, 4'd0, '0, MODE_SYS, '0, '0));
      send_req(make_req(KIND_EXCEPTION, 4'd0, '0, MODE_SYS, VEC_IRQ, '1));
      send_req(make_req(KIND_NOP, 4'd15, '1, '1, '1, '1));

      // Random part in three phases, each with its own vector base and idling pattern.
      for (int ph = 0; ph < 3; ph++) begin
         set_vector_base(bases[ph]);
         send_idle_pct = send_pcts[ph];
         recv_idle_pct <= recv_pcts[ph];
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            // A third of the way in the sender pauses until the block has drained, and midway
            // the receiver holds off while requests keep coming.
            if (n == RANDOM_PER_PHASE / 3) wait_idle();
            if (n == RANDOM_PER_PHASE / 2) hold_token <= hold_token + 1;
            send_req(random_req());
         end
      end

      wait_idle();
      repeat (5) @(posedge clock);
      $display("Run covered %0d requests, %0d mode switches and %0d exception entries,",
               sent_total, sent_switches, sent_exceptions);
      $display("under three vector bases, three stall patterns and long output hold-offs.");
      if (mismatch_count == 0 && awaited_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // A correct run takes well under a tenth of this.
   initial begin
      #4_000_000;
      $display("Timeout with %0d results still outstanding", awaited_count);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: banked_register_file_mode_switch.f
hdl/brfms_pkg.sv
hdl/brfms_ctrl.sv
hdl/brfms_datapath.sv
hdl/banked_register_file_mode_switch.sv
test/brfms_checker.sv
test/tb_banked_register_file_mode_switch.sv
